### src/pmsh_pkg.sv
package pmsh_pkg;

    localparam int ACC_W      = 32;
    localparam int CHAR_W     = 8;
    localparam int HASH_W     = 8;
    localparam int KEY_REGS   = 8;
    localparam int KEY_IDX_W  = $clog2(KEY_REGS);
    localparam int CFG_W      = 2 * ACC_W;
    localparam int POS_W      = 4;
    localparam int HASH_BITS_DEF = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPER,
        ST_MUL,
        ST_ADD,
        ST_TAIL,
        ST_OUT
    } seq_state_t;

    // one-hot style strobes from sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic load;   // form (c1 + k_lo) and (c2 + k_hi)
        logic mul;    // register low half of the product
        logic add;    // accumulate product
        logic clr;    // clear accumulator
    } mac_ctl_t;

    typedef struct packed {
        logic signed [CHAR_W-1:0] c1;
        logic signed [CHAR_W-1:0] c2;
    } pair_ops_t;

endpackage

### src/pairwise_multiply_string_hash.sv
// Keyed pairwise-multiply string hash, one character per transfer.
// A character that closes a pair stalls input while the shared 32x32 multiply-accumulate
// unit runs the operand, multiply and add states; other characters take no stall. A last
// transfer runs each open or padding pair (up to 8 pairs) through the tail, operand,
// multiply and add states, then loads the result in the output state.
// Reset (aresetn low, synchronous) clears the keys, accumulator, position and output valid flag.
module pairwise_multiply_string_hash
    import pmsh_pkg::*;
#(
    parameter int HASH_BITS = HASH_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CHAR_W-1:0]    s_tdata,   // [7:0] char_byte
    input  logic                 s_tlast,   // is_last
    input  logic [0:0]           s_tuser,   // [0] no_char
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [HASH_W-1:0]    m_tdata,   // [7:0] hash_value
    // key register writes
    input  logic                 cfg_we,
    input  logic [KEY_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int SHIFT = ACC_W - HASH_BITS;

    // Key pair registers: low half is the even key, high half the odd key.
    logic [CFG_W-1:0] key_reg [KEY_REGS];

    logic                 in_xfer;
    logic                 out_free;
    logic                 out_load;
    mac_ctl_t             ctl;
    pair_ops_t            ops;
    logic [KEY_IDX_W-1:0] pair_idx;
    logic [ACC_W-1:0]     sum;
    logic [ACC_W-1:0]     sum_shr;
    logic [CFG_W-1:0]     key_sel;

    logic                 m_valid_reg;
    logic [HASH_W-1:0]    m_data_reg;

    assign in_xfer  = s_tvalid && s_tready;
    // result register may reload as the current result transfers
    assign out_free = !m_valid_reg || m_tready;
    assign key_sel  = key_reg[pair_idx];
    assign sum_shr  = sum >> SHIFT;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_REGS; i++) begin
                key_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    // output register: separates the sequencer from downstream stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= sum_shr[HASH_W-1:0];
        end
    end

    pmsh_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_xfer  (in_xfer),
        .in_char  (s_tdata),
        .in_last  (s_tlast),
        .in_none  (s_tuser[0]),
        .out_free (out_free),
        .in_ready (s_tready),
        .out_load (out_load),
        .ctl      (ctl),
        .ops      (ops),
        .pair_idx (pair_idx)
    );

    pmsh_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .ops     (ops),
        .key_lo  (key_sel[ACC_W-1:0]),
        .key_hi  (key_sel[CFG_W-1:ACC_W]),
        .sum     (sum)
    );

endmodule

### src/pmsh_mac.sv
module pmsh_mac
    import pmsh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  mac_ctl_t          ctl,
    input  pair_ops_t         ops,
    input  logic [ACC_W-1:0]  key_lo,
    input  logic [ACC_W-1:0]  key_hi,
    output logic [ACC_W-1:0]  sum
);

    logic [ACC_W-1:0]   a_reg, b_reg, prod_reg, sum_reg;
    logic [2*ACC_W-1:0] prod_full;

    assign prod_full = a_reg * b_reg;
    assign sum       = sum_reg;

    // operand and product registers carry payload only
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            a_reg <= {{(ACC_W-CHAR_W){ops.c1[CHAR_W-1]}}, ops.c1} + key_lo;
            b_reg <= {{(ACC_W-CHAR_W){ops.c2[CHAR_W-1]}}, ops.c2} + key_hi;
        end
        if (ctl.mul) begin
            prod_reg <= prod_full[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctl.clr) begin
            sum_reg <= '0;
        end else if (ctl.add) begin
            sum_reg <= sum_reg + prod_reg;
        end
    end

endmodule

### src/pmsh_seq.sv
module pmsh_seq
    import pmsh_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_xfer,
    input  logic [CHAR_W-1:0]    in_char,
    input  logic                 in_last,
    input  logic                 in_none,
    input  logic                 out_free,
    output logic                 in_ready,
    output logic                 out_load,
    output mac_ctl_t             ctl,
    output pair_ops_t            ops,
    output logic [KEY_IDX_W-1:0] pair_idx
);

    seq_state_t           state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [CHAR_W-1:0]    held_reg, held_next;
    logic                 last_reg, last_next;
    pair_ops_t            ops_reg, ops_next;
    logic [KEY_IDX_W-1:0] idx_reg, idx_next;

    assign ops      = ops_reg;
    assign pair_idx = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            held_reg  <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        ops_reg <= ops_next;
        idx_reg <= idx_next;
    end

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        held_next  = held_reg;
        last_next  = last_reg;
        ops_next   = ops_reg;
        idx_next   = idx_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_xfer) begin
                    last_next = in_last;
                    if (!in_none) begin
                        pos_next = pos_reg + POS_W'(1);
                        if (!pos_reg[0]) begin
                            held_next  = in_char;
                            state_next = in_last ? ST_TAIL : ST_IDLE;
                        end else begin
                            ops_next.c1 = held_reg;
                            ops_next.c2 = in_char;
                            idx_next    = pos_reg[POS_W-1:1];
                            state_next  = ST_OPER;
                        end
                    end else if (in_last) begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_OPER: begin
                ctl.load   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                ctl.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                ctl.add    = 1'b1;
                state_next = last_reg ? ST_TAIL : ST_IDLE;
            end
            ST_TAIL: begin
                idx_next = pos_reg[POS_W-1:1];
                priority if (pos_reg[0]) begin
                    // open pair: partner counts as zero
                    ops_next.c1 = held_reg;
                    ops_next.c2 = '0;
                    pos_next    = pos_reg + POS_W'(1);
                    state_next  = ST_OPER;
                end else if (pos_reg != '0) begin
                    // zero padding pair
                    ops_next.c1 = '0;
                    ops_next.c2 = '0;
                    pos_next    = pos_reg + POS_W'(2);
                    state_next  = ST_OPER;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    ctl.clr    = 1'b1;
                    pos_next   = '0;
                    held_next  = '0;
                    last_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/pmsh_checker.sv
module pmsh_checker
    import pmsh_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tlast,
    input logic [0:0]        s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [HASH_W-1:0] m_tdata
);

    // no result survives reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // end of string always starts the tail sequence
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("ready right after last transfer");

    // an empty idle transfer does not stall the input
    a_idle_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast && s_tuser[0] |=> s_tready)
        else $error("idle transfer stalled input");

endmodule

bind pairwise_multiply_string_hash pmsh_checker u_pmsh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
